// ===== hdl/gpsm_pkg.sv =====
// gpsm_pkg: shared types and constants for the goose publisher sequence monitor
// used by gpsm_ctrl, gpsm_datapath and the top level

package gpsm_pkg;

  localparam int KindW = 2;
  localparam logic [KindW-1:0] KIND_UNRESOLVED = 2'd1;
  localparam logic [KindW-1:0] KIND_PUBLISH = 2'd2;

  localparam int NumAttr = 9;
  localparam int PrintW = 7;
  localparam int DigestAttr = 7;
  localparam int TtlPresentBit = 9;

  localparam int FindW = 16;
  localparam int F_UNRESOLVED = 0;
  localparam int F_SOURCE = 1;
  localparam int F_ST_REGRESS = 2;
  localparam int F_SQ_NONINCR = 3;
  localparam int F_NEW_STATE_SQ = 4;
  localparam int F_TTL = 5;
  localparam int F_INTERVAL = 6;
  localparam int F_ATTR0 = 7;

  // register indexes on the config port
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the input item and start table reads
    logic evaluate;    // run checks, write tables, load output register
    logic unresolved;  // result is the unresolved-identity form
  } gpsm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;    // output register holds an item not yet taken
  } gpsm_status_t;

endpackage

// ===== hdl/goose_publisher_sequence_monitor.sv =====
// goose_publisher_sequence_monitor: top level, config registers and stream ports
// depends on gpsm_pkg, gpsm_ctrl, gpsm_datapath

// Checks decoded GOOSE publish items against per-stream and per-publisher
// slot tables and returns one findings item per publish or unresolved item.
// A publish item is first captured, reading both tables into registers, then
// evaluated: checked, written back and loaded into the output register. No
// new item is accepted while one is evaluated or an output item is untaken.
// Items of kind 0 or 3 give no result. Valid bits are cleared by reset at once.
module goose_publisher_sequence_monitor #(
  parameter int STREAM_SLOTS = 64,
  parameter int PUBLISHER_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // item_kind[1:0], logical_slot[7:2], stream_slot[13:8], source_id[61:14],
  // state_number[93:62], sequence_number[125:94], is_reordered[126],
  // time_us[174:127], frame_number[206:175], ttl_ms[238:207],
  // attr_present[248:239], attr_fingerprints[311:249], zero fill
  input  logic [319:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // findings[15:0], prev_frame[47:16], prev_logical_frame[79:48],
  // interarrival_us[128:80], zero fill
  output logic [135:0] m_tdata
);
  import gpsm_pkg::*;

  logic [31:0] interval_us, tolerance_us;
  gpsm_cmd_t    cmd;
  gpsm_status_t status;
  logic [15:0]  findings;
  logic [31:0]  prev_frame, prev_logical_frame;
  logic [48:0]  interarrival_us;

  assign pready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_us <= '0;
      tolerance_us <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_INTERVAL) interval_us <= pwdata;
      else tolerance_us <= pwdata;
    end
  end

  assign prdata = (paddr[1:0] != 2'b00) ? 32'd0 :
                  (paddr[2] == REG_TOLERANCE) ? tolerance_us : interval_us;

  gpsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_kind(s_tdata[1:0]), .status(status), .cmd(cmd)
  );

  gpsm_datapath #(.STREAM_SLOTS(STREAM_SLOTS), .PUBLISHER_SLOTS(PUBLISHER_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .interval_us(interval_us), .tolerance_us(tolerance_us),
    .logical_slot(s_tdata[7:2]), .stream_slot(s_tdata[13:8]),
    .source_id(s_tdata[61:14]), .state_number(s_tdata[93:62]),
    .sequence_number(s_tdata[125:94]), .is_reordered(s_tdata[126]),
    .time_us(s_tdata[174:127]), .frame_number(s_tdata[206:175]),
    .ttl_ms(s_tdata[238:207]), .attr_present(s_tdata[248:239]),
    .attr_fingerprints(s_tdata[311:249]),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .findings(findings),
    .prev_frame(prev_frame), .prev_logical_frame(prev_logical_frame),
    .interarrival_us(interarrival_us)
  );

  assign m_tdata = {7'd0, interarrival_us, prev_logical_frame, prev_frame, findings};
endmodule

// ===== hdl/gpsm_ctrl.sv =====
// gpsm_ctrl: controller state machine, capture then evaluate for each publish or unresolved item
// depends on gpsm_pkg

module gpsm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_kind,
  input  gpsm_pkg::gpsm_status_t status,
  output gpsm_pkg::gpsm_cmd_t   cmd
);
  import gpsm_pkg::*;

  typedef enum logic {S_IDLE, S_EVAL} state_t;
  state_t state;
  logic   unres;

  // accept only when idle and the output register can take the result
  assign s_tready = (state == S_IDLE) && !status.out_busy;

  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.evaluate = (state == S_EVAL);
  assign cmd.unresolved = unres;

  // state and registered kind flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      unres <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready &&
              (s_kind == KIND_PUBLISH || s_kind == KIND_UNRESOLVED)) begin
            state <= S_EVAL;
            unres <= (s_kind == KIND_UNRESOLVED);
          end
        end
        S_EVAL: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/gpsm_datapath.sv =====
// gpsm_datapath: slot tables, checks and output register
// depends on gpsm_pkg

module gpsm_datapath #(
  parameter int STREAM_SLOTS = 64,
  parameter int PUBLISHER_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gpsm_pkg::gpsm_cmd_t    cmd,
  output gpsm_pkg::gpsm_status_t status,
  input  logic [31:0]            interval_us,
  input  logic [31:0]            tolerance_us,
  input  logic [5:0]             logical_slot,
  input  logic [5:0]             stream_slot,
  input  logic [47:0]            source_id,
  input  logic [31:0]            state_number,
  input  logic [31:0]            sequence_number,
  input  logic                   is_reordered,
  input  logic [47:0]            time_us,
  input  logic [31:0]            frame_number,
  input  logic [31:0]            ttl_ms,
  input  logic [9:0]             attr_present,
  input  logic [62:0]            attr_fingerprints,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            findings,
  output logic [31:0]            prev_frame,
  output logic [31:0]            prev_logical_frame,
  output logic [48:0]            interarrival_us
);
  import gpsm_pkg::*;

  localparam int SW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam int PW = (PUBLISHER_SLOTS > 1) ? $clog2(PUBLISHER_SLOTS) : 1;

  // stream entry, stored as one word
  typedef struct packed {
    logic [31:0] st;
    logic [31:0] sq;
    logic [47:0] tm;
    logic [31:0] fr;
    logic [31:0] ttl;
    logic [9:0]  pres;
    logic [62:0] prints;
  } sentry_t;

  typedef struct packed {
    logic [47:0] src;
    logic [31:0] fr;
  } pentry_t;

  sentry_t smem [STREAM_SLOTS];
  pentry_t pmem [PUBLISHER_SLOTS];
  logic [STREAM_SLOTS-1:0]    svalid;
  logic [PUBLISHER_SLOTS-1:0] pvalid;

  // captured item
  logic [SW-1:0] ss;
  logic [PW-1:0] ls;
  sentry_t       cur;
  logic [47:0]   csrc;
  logic          creord;

  // registered table reads
  sentry_t s_rd;
  pentry_t p_rd;
  logic    s_hit, p_hit;

  logic [SW-1:0] ss_in;
  logic [PW-1:0] ls_in;
  logic [SW-1:0] smod [64];
  logic [PW-1:0] lmod [64];

  // slot numbers folded onto the table depth, fixed lookup per slot
  for (genvar g = 0; g < 64; g++) begin : g_slot_mod
    assign smod[g] = SW'(g % STREAM_SLOTS);
    assign lmod[g] = PW'(g % PUBLISHER_SLOTS);
  end
  assign ss_in = smod[stream_slot];
  assign ls_in = lmod[logical_slot];

  // capture and read cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ss <= ss_in;
      ls <= ls_in;
      cur <= '{st: state_number, sq: sequence_number, tm: time_us, fr: frame_number,
               ttl: ttl_ms, pres: attr_present, prints: attr_fingerprints};
      csrc <= source_id;
      creord <= is_reordered;
      s_rd <= smem[ss_in];
      p_rd <= pmem[ls_in];
      s_hit <= svalid[ss_in];
      p_hit <= pvalid[ls_in];
    end
  end

  // checks
  logic signed [48:0] dt;
  logic [15:0]        f;
  logic [47:0]        ttl_lim;
  logic [49:0]        dev;
  logic               same_st, wrap;

  assign dt = $signed({1'b0, cur.tm}) - $signed({1'b0, s_rd.tm});
  assign ttl_lim = 48'(s_rd.ttl) * 48'd1000;
  assign dev = dt[48] ? 50'd0 :
               ((49'(dt) >= 49'(interval_us)) ? 50'(49'(dt) - 49'(interval_us))
                                             : 50'(49'(interval_us) - 49'(dt)));
  assign same_st = (cur.st == s_rd.st);
  assign wrap = (s_rd.st == 32'hFFFF_FFFF) && (cur.st == 32'd1);

  always_comb begin
    f = '0;
    if (p_hit && p_rd.src != csrc) f[F_SOURCE] = 1'b1;
    if (s_hit) begin
      if (!creord) begin
        f[F_ST_REGRESS] = (cur.st < s_rd.st) && !wrap;
        f[F_SQ_NONINCR] = same_st && (cur.sq <= s_rd.sq);
        f[F_NEW_STATE_SQ] = !same_st && (cur.sq != 32'd0);
      end
      for (int k = 0; k < NumAttr; k++) begin
        if (cur.pres[k] && s_rd.pres[k] &&
            cur.prints[k*PrintW +: PrintW] != s_rd.prints[k*PrintW +: PrintW] &&
            !(k == DigestAttr && !same_st))
          f[F_ATTR0 + k] = 1'b1;
      end
      f[F_TTL] = !dt[48] && s_rd.pres[TtlPresentBit] && (dt[47:0] > ttl_lim);
      f[F_INTERVAL] = (interval_us != 32'd0) && !dt[48] &&
                      (dev > 50'(tolerance_us));
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.evaluate && !cmd.unresolved) begin
      pmem[ls] <= '{src: csrc, fr: cur.fr};
      if (!creord) smem[ss] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svalid <= '0;
      pvalid <= '0;
    end else if (cmd.evaluate && !cmd.unresolved) begin
      pvalid[ls] <= 1'b1;
      if (!creord) svalid[ss] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.evaluate) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      if (cmd.unresolved) begin
        findings <= 16'(1 << F_UNRESOLVED);
        prev_frame <= '0;
        prev_logical_frame <= '0;
        interarrival_us <= '0;
      end else begin
        findings <= f;
        prev_frame <= s_hit ? s_rd.fr : 32'd0;
        prev_logical_frame <= p_hit ? p_rd.fr : 32'd0;
        interarrival_us <= s_hit ? dt : 49'sd0;
      end
    end
  end

  assign status.out_busy = m_tvalid && !m_tready;
endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for goose_publisher_sequence_monitor
// depends on gpsm_pkg and the goose_publisher_sequence_monitor rtl
`timescale 1ns / 1ps

module tb_top;
  import gpsm_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  lslot;
    logic [5:0]  sslot;
    logic [47:0] src;
    logic [31:0] stnum;
    logic [31:0] sqnum;
    logic        reord;
    logic [47:0] tus;
    logic [31:0] frame;
    logic [31:0] ttl;
    logic [9:0]  pres;
    logic [62:0] prints;
  } goose_obs_t;

  typedef struct {
    logic [15:0] findings;
    logic [31:0] pframe;
    logic [31:0] plframe;
    logic [48:0] gap;
  } finding_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 0;
  logic s_tready;
  logic [319:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [135:0] m_tdata;

  goose_publisher_sequence_monitor i_dut (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [31:0] cfg_interval, cfg_tolerance;
  logic        st_valid [64];
  logic [31:0] st_stnum [64], st_sqnum [64], st_frame [64], st_ttl [64];
  logic [47:0] st_time [64];
  logic [9:0]  st_pres [64];
  logic [62:0] st_prints [64];
  logic        pub_valid [64];
  logic [47:0] pub_src [64];
  logic [31:0] pub_frame [64];

  goose_obs_t obs_pending[$];
  finding_t   findings_expected[$];
  int errors = 0;
  int results_seen = 0;
  int sent = 0;
  bit hold_rx = 0;
  bit cfg_busy = 0;

  function automatic logic [319:0] pack_obs(goose_obs_t o);
    return {8'd0, o.prints, o.pres, o.ttl, o.frame, o.tus, o.reord, o.sqnum, o.stnum,
            o.src, o.sslot, o.lslot, o.kind};
  endfunction

  // compute the findings item for one observation and update tables
  task automatic predict_findings(goose_obs_t o);
    finding_t r;
    logic signed [49:0] dt;
    logic signed [50:0] dev;
    logic [6:0] a, b;
    int s, l;
    s = o.sslot;
    l = o.lslot;
    r = '{16'd0, 32'd0, 32'd0, 49'd0};
    if (o.kind == KIND_UNRESOLVED) begin
      r.findings[F_UNRESOLVED] = 1'b1;
      findings_expected.push_back(r);
      return;
    end
    if (o.kind != KIND_PUBLISH) return;
    if (pub_valid[l]) begin
      r.plframe = pub_frame[l];
      if (pub_src[l] != o.src) r.findings[F_SOURCE] = 1'b1;
    end
    pub_valid[l] = 1'b1;
    pub_src[l] = o.src;
    pub_frame[l] = o.frame;
    if (st_valid[s]) begin
      dt = $signed({2'b00, o.tus}) - $signed({2'b00, st_time[s]});
      r.pframe = st_frame[s];
      r.gap = dt[48:0];
      if (!o.reord) begin
        if (o.stnum < st_stnum[s] && !(st_stnum[s] == 32'hFFFFFFFF && o.stnum == 32'd1))
          r.findings[F_ST_REGRESS] = 1'b1;
        if (o.stnum == st_stnum[s] && o.sqnum <= st_sqnum[s])
          r.findings[F_SQ_NONINCR] = 1'b1;
        if (o.stnum != st_stnum[s] && o.sqnum != 0) r.findings[F_NEW_STATE_SQ] = 1'b1;
      end
      for (int k = 0; k < NumAttr; k++) begin
        a = o.prints[PrintW*k +: PrintW];
        b = st_prints[s][PrintW*k +: PrintW];
        if (o.pres[k] && st_pres[s][k] && a != b &&
            !(k == DigestAttr && o.stnum != st_stnum[s]))
          r.findings[F_ATTR0 + k] = 1'b1;
      end
      if (dt >= 0 && st_pres[s][TtlPresentBit] &&
          64'(dt) > 64'(st_ttl[s]) * 64'd1000)
        r.findings[F_TTL] = 1'b1;
      if (cfg_interval != 0 && dt >= 0) begin
        dev = dt - $signed({19'd0, cfg_interval});
        if (dev < 0) dev = -dev;
        if (dev > $signed({19'd0, cfg_tolerance})) r.findings[F_INTERVAL] = 1'b1;
      end
    end
    if (!o.reord) begin
      st_valid[s] = 1'b1;
      st_stnum[s] = o.stnum;
      st_sqnum[s] = o.sqnum;
      st_time[s] = o.tus;
      st_frame[s] = o.frame;
      st_ttl[s] = o.ttl;
      st_pres[s] = o.pres;
      st_prints[s] = o.prints;
    end
    findings_expected.push_back(r);
  endtask

  // sender: one item from the pending queue, random gap after each accepted item
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_findings(obs_pending.pop_front());
        sent++;
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (obs_pending.size() > 0 && !cfg_busy) begin
        s_tvalid <= 1'b1;
        s_tdata <= pack_obs(obs_pending[0]);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: check each result against the oldest expectation
  int rx_wait = 0;
  finding_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[15:0], m_tdata[47:16], m_tdata[79:48], m_tdata[128:80]};
        results_seen++;
        if (findings_expected.size() == 0) begin
          $display("%0t unexpected result findings=%h", $time, got.findings);
          errors++;
        end else begin
          want = findings_expected.pop_front();
          if (got.findings !== want.findings) begin
            $display("%0t findings exp %h got %h", $time, want.findings, got.findings);
            errors++;
          end
          if (got.pframe !== want.pframe) begin
            $display("%0t prev_frame exp %h got %h", $time, want.pframe, got.pframe);
            errors++;
          end
          if (got.plframe !== want.plframe) begin
            $display("%0t prev_logical_frame exp %h got %h", $time, want.plframe,
                     got.plframe);
            errors++;
          end
          if (got.gap !== want.gap) begin
            $display("%0t interarrival exp %h got %h", $time, want.gap, got.gap);
            errors++;
          end
        end
        rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (hold_rx) begin
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) cfg_interval = val; else cfg_tolerance = val;
  endtask

  // wait for idle, then reprogram the interval check
  task automatic set_interval(logic [31:0] ival, logic [31:0] tol);
    wait (obs_pending.size() == 0 && findings_expected.size() == 0);
    cfg_busy = 1;
    repeat (6) @(posedge clk);
    write_reg(3'd4 * REG_INTERVAL, ival);
    write_reg(3'd4 * REG_TOLERANCE, tol);
    cfg_busy = 0;
  endtask

  function automatic goose_obs_t rand_obs();
    goose_obs_t o;
    o.kind = 2'($urandom_range(0, 3));
    o.lslot = 6'($urandom);
    o.sslot = 6'($urandom);
    o.src = 48'({$urandom, $urandom});
    o.stnum = $urandom;
    o.sqnum = $urandom;
    o.reord = 1'($urandom);
    o.tus = 48'({$urandom, $urandom});
    o.frame = $urandom;
    o.ttl = $urandom;
    o.pres = 10'($urandom);
    o.prints = 63'({$urandom, $urandom});
    return o;
  endfunction

  // well-formed traffic on a few streams: mostly in order, occasional oddities
  logic [31:0] w_st [8], w_sq [8];
  logic [47:0] w_t [8];
  logic [62:0] w_pr [8];
  logic [31:0] w_frame = 0;
  task automatic queue_stream(int count);
    goose_obs_t o;
    int j;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        o = rand_obs();
      end else begin
        j = $urandom_range(0, 7);
        if ($urandom_range(0, 4) == 0) begin
          w_st[j] = ($urandom_range(0, 9) == 0) ? 32'hFFFFFFFF : w_st[j] + 1;
          w_sq[j] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        end else begin
          w_sq[j] = w_sq[j] + (($urandom_range(0, 7) == 0) ? 0 : 1);
        end
        if ($urandom_range(0, 4) == 0) w_pr[j][$urandom_range(0, 62)] ^= 1'b1;
        w_t[j] = w_t[j] + 48'($urandom_range(900, 1100)) -
                 48'(($urandom_range(0, 30) == 0) ? 3000 : 0);
        o.kind = KIND_PUBLISH;
        o.lslot = 6'(j + 8 * ($urandom_range(0, 6) == 0));
        o.sslot = 6'(j);
        o.src = ($urandom_range(0, 15) == 0) ? 48'({$urandom, $urandom}) : 48'(j);
        o.stnum = w_st[j];
        o.sqnum = w_sq[j];
        o.reord = ($urandom_range(0, 12) == 0);
        o.tus = w_t[j];
        o.frame = ++w_frame;
        o.ttl = $urandom_range(0, 2);
        o.pres = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'h3FF;
        o.prints = w_pr[j];
      end
      obs_pending.push_back(o);
    end
  endtask

  initial begin
    goose_obs_t o;
    cfg_interval = 0;
    cfg_tolerance = 0;
    for (int i = 0; i < 64; i++) begin
      st_valid[i] = 0;
      pub_valid[i] = 0;
    end
    for (int j = 0; j < 8; j++) begin
      w_st[j] = $urandom_range(1, 5);
      w_sq[j] = 0;
      w_t[j] = 48'd1000000 * j;
      w_pr[j] = 63'({$urandom, $urandom});
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_interval(32'd1000, 32'd50);

    // directed: extremes, kinds, wrap, reorder, digest, ttl, negative gap
    o = '{KIND_UNRESOLVED, 6'd63, 6'd63, '1, '1, '1, 1'b1, '1, '1, '1, '1, '1};
    obs_pending.push_back(o);
    o.kind = 2'd0; obs_pending.push_back(o);
    o.kind = 2'd3; obs_pending.push_back(o);
    o = '{KIND_PUBLISH, 6'd63, 6'd63, '1, 32'hFFFFFFFF, 32'd5, 1'b0, 48'd5000, 32'd1,
          32'd1, 10'h3FF, 63'd0};
    obs_pending.push_back(o);
    o.stnum = 1; o.sqnum = 0; o.tus = 48'd6000; o.frame = 2; obs_pending.push_back(o);
    o.sqnum = 0; o.tus = 48'd8500; o.frame = 3; o.prints = '1; obs_pending.push_back(o);
    o.stnum = 0; o.sqnum = 7; o.tus = 48'd100; o.frame = 4; o.reord = 1;
    obs_pending.push_back(o);
    o.reord = 0; o.src = 0; o.tus = 48'd0; o.frame = 5; obs_pending.push_back(o);
    o.stnum = 0; o.sqnum = 1; o.tus = '1; o.frame = 6; o.prints = 63'(1) << 49;
    obs_pending.push_back(o);
    o = '{KIND_PUBLISH, 6'd0, 6'd0, 48'd0, 32'd0, 32'd0, 1'b0, 48'd0, 32'd0, 32'd0,
          10'd0, 63'd0};
    obs_pending.push_back(o);
    o.tus = 48'd1000; o.sqnum = 1; o.frame = 9; obs_pending.push_back(o);
    for (int n = 0; n < 10; n++) obs_pending.push_back(rand_obs());

    set_interval(32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_stream(200);
    set_interval(32'd0, 32'd0);
    queue_stream(200);
    // receiver holds off while the sender keeps offering
    fork
      begin
        wait (sent > 430);
        hold_rx = 1;
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end
    join_none
    set_interval(32'd1000, 32'd60);
    queue_stream(300);
    // sender pause until all results in
    wait (obs_pending.size() == 0 && findings_expected.size() == 0);
    for (int n = 0; n < 200; n++) obs_pending.push_back(rand_obs());
    set_interval($urandom, $urandom);
    queue_stream(500);

    wait (obs_pending.size() == 0 && findings_expected.size() == 0);
    repeat (40) @(posedge clk);
    $display("sent %0d items, checked %0d results over several interval settings",
             sent, results_seen);
    if (errors == 0 && findings_expected.size() == 0)
      $display("PASS goose_publisher_sequence_monitor");
    else
      $display("FAIL goose_publisher_sequence_monitor");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL goose_publisher_sequence_monitor");
    $finish;
  end
endmodule
